// ===== src/assert_macros.svh =====
// Assertion macros shared by the matcher RTL.
// Clocked on i_clk and disabled while i_rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LOB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("lob assertion failed");
`define LOB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lob assertion failed");
`define LOB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lob assertion failed");
`else
`define LOB_ASSERT(lbl, prop)
`define LOB_ASSERT_IMP(lbl, ante, cons)
`define LOB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/lob_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the order book matcher.
// Used by lob_ctrl, lob_dp, limit_order_book_matcher and the bench; no dependencies.
package lob_pkg;

    localparam logic [15:0] GAS_BASE_RST     = 16'd1500;
    localparam logic [15:0] GAS_PER_FILL_RST = 16'd350;

    // register indexes on the configuration port
    localparam logic [0:0] CFG_GAS_BASE     = 1'b0;
    localparam logic [0:0] CFG_GAS_PER_FILL = 1'b1;

    typedef struct packed {
        logic start;      // latch incoming request
        logic m_rd;       // read best opposite entry
        logic m_apply;    // take a fill against it
        logic mul_step;   // one notional partial product
        logic rest_init;  // begin insertion walk
        logic set_drop;   // side full, flag leftover
        logic r_rd;       // read own entry ahead of the slot
        logic r_shift;    // move that entry one slot back
        logic r_ins;      // write the leftover into the slot
        logic div_init;
        logic div_step;
        logic gas_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic pre_ok;
        logic match_go;
        logic crosses;
        logic mul_last;
        logic rest_go;
        logic side_full;
        logic slot_zero;
        logic moves;
        logic filled_zero;
        logic div_last;
    } t_sts;

endpackage

// ===== src/lob_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the order book matcher: walks one request through match,
// rest, divide and report. Uses lob_pkg command and status types.
module lob_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_stall,
    input  lob_pkg::t_sts i_sts,
    output lob_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_out_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MREAD = 4'd1;
    localparam logic [3:0] S_MCHK  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_REST  = 4'd4;
    localparam logic [3:0] S_RRD   = 4'd5;
    localparam logic [3:0] S_RCHK  = 4'd6;
    localparam logic [3:0] S_DINIT = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_GAS   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = i_sts.pre_ok ? S_MREAD : S_DONE;
                end
            end
            S_MREAD: begin
                if (i_sts.match_go) begin
                    o_cmd.m_rd = 1'b1;
                    n_state = S_MCHK;
                end else begin
                    n_state = S_REST;
                end
            end
            S_MCHK: begin
                if (i_sts.crosses) begin
                    o_cmd.m_apply = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_REST;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) n_state = S_MREAD;
            end
            S_REST: begin
                if (i_sts.rest_go && !i_sts.side_full) begin
                    o_cmd.rest_init = 1'b1;
                    n_state = S_RRD;
                end else begin
                    o_cmd.set_drop = i_sts.rest_go;
                    n_state = S_DINIT;
                end
            end
            S_RRD: begin
                if (i_sts.slot_zero) begin
                    o_cmd.r_ins = 1'b1;
                    n_state = S_DINIT;
                end else begin
                    o_cmd.r_rd = 1'b1;
                    n_state = S_RCHK;
                end
            end
            S_RCHK: begin
                if (i_sts.moves) begin
                    o_cmd.r_shift = 1'b1;
                    n_state = S_RRD;
                end else begin
                    o_cmd.r_ins = 1'b1;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state = i_sts.filled_zero ? S_GAS : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_GAS;
            end
            S_GAS: begin
                o_cmd.gas_step = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!(r_out_valid && i_out_stall)) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/lob_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the order book matcher: book memories kept as rings per book,
// counts, notional multiplier, bit-serial divider and result register. Uses lob_pkg.
module lob_dp #(
    parameter int NUM_BOOKS  = 4,
    parameter int BOOK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lob_pkg::t_cmd i_cmd,
    output lob_pkg::t_sts o_sts,
    input  logic [15:0]   i_gas_base,
    input  logic [15:0]   i_gas_per_fill,
    input  logic          i_in_side,
    input  logic [63:0]   i_in_limit_price,
    input  logic [63:0]   i_in_order_qty,
    input  logic [1:0]    i_in_book_index,
    input  logic [63:0]   i_in_gas_limit,
    output logic          o_out_status,
    output logic [63:0]   o_out_filled_qty,
    output logic [63:0]   o_out_avg_price,
    output logic [6:0]    o_out_num_fills,
    output logic [22:0]   o_out_gas_charge,
    output logic          o_out_rest_dropped
);

    localparam int BW    = (NUM_BOOKS > 1) ? $clog2(NUM_BOOKS) : 1;
    localparam int DW    = $clog2(BOOK_DEPTH);
    localparam int CW    = $clog2(BOOK_DEPTH + 1);
    localparam int SLOTS = NUM_BOOKS * BOOK_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int GPW   = CW + 16;
    localparam logic [DW:0]   DEPTH_W = (DW + 1)'(BOOK_DEPTH);
    localparam logic [AW-1:0] DEPTH_A = AW'(BOOK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BOOK_DEPTH);

    function automatic logic [DW-1:0] f_wrap(input logic [DW-1:0] h, input logic [DW-1:0] off);
        logic [DW:0] s;
        s = {1'b0, h} + {1'b0, off};
        if (s >= DEPTH_W) s = s - DEPTH_W;
        return s[DW-1:0];
    endfunction

    function automatic logic [AW-1:0] f_phys(input logic [BW-1:0] b, input logic [DW-1:0] r);
        return AW'(b) * DEPTH_A + AW'(r);
    endfunction

    // request registers
    logic          r_side;
    logic [63:0]   r_limit;
    logic [63:0]   r_rem;
    logic [63:0]   r_glimit;
    logic [BW-1:0] r_book;
    logic          r_pre_fail;
    logic [63:0]   r_filled;
    logic [127:0]  r_acc;
    logic [CW-1:0] r_fills;
    logic          r_dropped;
    logic [CW-1:0] r_j;

    // book state
    logic [CW-1:0] r_bid_cnt  [NUM_BOOKS];
    logic [CW-1:0] r_ask_cnt  [NUM_BOOKS];
    logic [DW-1:0] r_bid_head [NUM_BOOKS];
    logic [DW-1:0] r_ask_head [NUM_BOOKS];
    logic [127:0]  r_bid_mem  [SLOTS];
    logic [127:0]  r_ask_mem  [SLOTS];
    logic [127:0]  r_bid_q;
    logic [127:0]  r_ask_q;
    logic          r_rd_is_bid;

    // multiplier and divider
    logic [63:0]   r_fq;
    logic [63:0]   r_tp;
    logic [2:0]    r_mstep;
    logic [63:0]   r_prod;
    logic [1:0]    r_psh;
    logic [127:0]  r_dvd;
    logic [63:0]   r_drem;
    logic [63:0]   r_quot;
    logic [6:0]    r_dcnt;
    logic [GPW-1:0] r_gprod;

    logic [1:0]    bk_v;
    logic [BW-1:0] in_book;
    logic [CW-1:0] bid_cnt_b, ask_cnt_b, op_cnt, own_cnt;
    logic [DW-1:0] bid_head_b, ask_head_b, op_head, own_head;
    logic [127:0]  rd_data;
    logic [63:0]   tp, tq, fq;
    logic          partial;
    logic [CW-1:0] j_m1;
    logic          rd_en, rd_bid;
    logic [AW-1:0] raddr;
    logic          we, wbid;
    logic [AW-1:0] waddr;
    logic [127:0]  wdata;
    logic [31:0]   a_half, b_half;
    logic [127:0]  sh_prod;
    logic [63:0]   rem2;
    logic          ge;
    logic [63:0]   gas_full;
    logic [63:0]   fills64;

    // fold the book selector into range
    always_comb begin
        bk_v = i_in_book_index;
        for (int s = 0; s < 3; s++) begin
            if (32'(bk_v) >= NUM_BOOKS) bk_v = bk_v - 2'(NUM_BOOKS);
        end
        in_book = BW'(bk_v);
    end

    assign bid_cnt_b  = r_bid_cnt[r_book];
    assign ask_cnt_b  = r_ask_cnt[r_book];
    assign bid_head_b = r_bid_head[r_book];
    assign ask_head_b = r_ask_head[r_book];
    assign op_cnt     = r_side ? bid_cnt_b : ask_cnt_b;
    assign own_cnt    = r_side ? ask_cnt_b : bid_cnt_b;
    assign op_head    = r_side ? bid_head_b : ask_head_b;
    assign own_head   = r_side ? ask_head_b : bid_head_b;

    assign rd_data = r_rd_is_bid ? r_bid_q : r_ask_q;
    assign tp      = rd_data[127:64];
    assign tq      = rd_data[63:0];
    assign fq      = (r_rem < tq) ? r_rem : tq;
    assign partial = (fq < tq);
    assign j_m1    = r_j - CW'(1);

    assign o_sts.pre_ok      = (i_in_gas_limit >= 64'(i_gas_base));
    assign o_sts.match_go    = (op_cnt != '0) && (r_rem != '0);
    assign o_sts.crosses     = r_side ? (r_limit <= tp) : (tp <= r_limit);
    assign o_sts.mul_last    = (r_mstep == 3'd4);
    assign o_sts.rest_go     = (r_rem != '0);
    assign o_sts.side_full   = (own_cnt >= DEPTH_C);
    assign o_sts.slot_zero   = (r_j == '0);
    assign o_sts.moves       = r_side ? (r_limit < tp) : (r_limit > tp);
    assign o_sts.filled_zero = (r_filled == '0);
    assign o_sts.div_last    = (r_dcnt == 7'd127);

    // memory port steering
    always_comb begin
        rd_en = i_cmd.m_rd || i_cmd.r_rd;
        if (i_cmd.m_rd) begin
            rd_bid = r_side;
            raddr  = f_phys(r_book, op_head);
        end else begin
            rd_bid = !r_side;
            raddr  = f_phys(r_book, f_wrap(own_head, j_m1[DW-1:0]));
        end
        we = (i_cmd.m_apply && partial) || i_cmd.r_shift || i_cmd.r_ins;
        if (i_cmd.m_apply) begin
            wbid  = r_side;
            waddr = f_phys(r_book, op_head);
            wdata = {tp, tq - fq};
        end else begin
            wbid  = !r_side;
            waddr = f_phys(r_book, f_wrap(own_head, r_j[DW-1:0]));
            wdata = i_cmd.r_shift ? rd_data : {r_limit, r_rem};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && wbid) r_bid_mem[waddr] <= wdata;
        if (rd_en && rd_bid) r_bid_q <= r_bid_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we && !wbid) r_ask_mem[waddr] <= wdata;
        if (rd_en && !rd_bid) r_ask_q <= r_ask_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_is_bid <= rd_bid;
    end

    // counts and ring heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BOOKS; b++) begin
                r_bid_cnt[b]  <= '0;
                r_ask_cnt[b]  <= '0;
                r_bid_head[b] <= '0;
                r_ask_head[b] <= '0;
            end
        end else begin
            if (i_cmd.m_apply && !partial) begin
                // resting order consumed: advance past it
                if (r_side) begin
                    r_bid_head[r_book] <= f_wrap(bid_head_b, DW'(1));
                    r_bid_cnt[r_book]  <= bid_cnt_b - CW'(1);
                end else begin
                    r_ask_head[r_book] <= f_wrap(ask_head_b, DW'(1));
                    r_ask_cnt[r_book]  <= ask_cnt_b - CW'(1);
                end
            end
            if (i_cmd.r_ins) begin
                if (r_side) r_ask_cnt[r_book] <= ask_cnt_b + CW'(1);
                else r_bid_cnt[r_book] <= bid_cnt_b + CW'(1);
            end
        end
    end

    // partial products of fill quantity times price
    assign a_half = r_mstep[0] ? r_fq[63:32] : r_fq[31:0];
    assign b_half = r_mstep[1] ? r_tp[63:32] : r_tp[31:0];

    always_comb begin
        case (r_psh)
            2'd0:    sh_prod = {64'd0, r_prod};
            2'd1:    sh_prod = {32'd0, r_prod, 32'd0};
            default: sh_prod = {r_prod, 64'd0};
        endcase
    end

    assign rem2 = {r_drem[62:0], r_dvd[127]};
    assign ge   = r_drem[63] || (rem2 >= r_filled);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_side     <= i_in_side;
            r_limit    <= i_in_limit_price;
            r_rem      <= i_in_order_qty;
            r_glimit   <= i_in_gas_limit;
            r_book     <= in_book;
            r_pre_fail <= !o_sts.pre_ok;
            r_filled   <= '0;
            r_acc      <= '0;
            r_fills    <= '0;
            r_dropped  <= 1'b0;
        end
        if (i_cmd.m_apply) begin
            r_fq     <= fq;
            r_tp     <= tp;
            r_mstep  <= '0;
            r_filled <= r_filled + fq;
            r_rem    <= r_rem - fq;
            r_fills  <= r_fills + CW'(1);
        end
        if (i_cmd.mul_step) begin
            if (r_mstep != 3'd4) begin
                r_prod <= a_half * b_half;
                r_psh  <= 2'(r_mstep[0]) + 2'(r_mstep[1]);
            end
            if (r_mstep != 3'd0) r_acc <= r_acc + sh_prod;
            r_mstep <= r_mstep + 3'd1;
        end
        if (i_cmd.set_drop) r_dropped <= 1'b1;
        if (i_cmd.rest_init) r_j <= own_cnt;
        if (i_cmd.r_shift) r_j <= j_m1;
        if (i_cmd.div_init) begin
            r_dvd  <= r_acc;
            r_drem <= '0;
            r_quot <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_drem <= ge ? rem2 - r_filled : rem2;
            r_quot <= {r_quot[62:0], ge};
            r_dvd  <= {r_dvd[126:0], 1'b0};
            r_dcnt <= r_dcnt + 7'd1;
        end
        if (i_cmd.gas_step) r_gprod <= GPW'(r_fills) * GPW'(i_gas_per_fill);
    end

    assign gas_full = 64'(i_gas_base) + 64'(r_gprod);
    assign fills64  = 64'(r_fills);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_pre_fail) begin
                o_out_status       <= 1'b1;
                o_out_filled_qty   <= '0;
                o_out_avg_price    <= '0;
                o_out_num_fills    <= '0;
                o_out_gas_charge   <= '0;
                o_out_rest_dropped <= 1'b0;
            end else begin
                o_out_status       <= (gas_full > r_glimit);
                o_out_filled_qty   <= r_filled;
                o_out_avg_price    <= r_quot;
                o_out_num_fills    <= fills64[6:0];
                o_out_gas_charge   <= gas_full[22:0];
                o_out_rest_dropped <= r_dropped;
            end
        end
    end

endmodule

// ===== src/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// Limit order book matcher top level: configuration port, sequencer and datapath.
// Depends on lob_pkg, lob_ctrl, lob_dp and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall) takes one limit order per request;
// output channel (o_out_valid / i_out_stall) returns one result per request.
// o_in_stall is low only while the block is idle; a finished result waits in
// the output register, so the next request is taken while it is stalled.
// Per request, each resting order crossed is read, compared and priced with four
// 32x32 partial products; the walk ends when the order is done, the side is empty
// or a price does not cross. The leftover is then inserted by shifting own-side
// entries until one stays or the head is reached. A failed gas precheck skips
// straight to the result. The VWAP divider runs only when something filled and
// retires one quotient bit per cycle.
// Each book side is a ring in one single-port-read memory per side, so every
// fill and every shift step costs a memory read.
// Reset (synchronous, i_rst_n low) empties all books and loads gas_base 1500
// and gas_per_fill 350; book entries need no clearing pass.
// If the receiver stalls, the result holds and the next one waits in DONE.
// Registers: gas_base at 0x0, gas_per_fill at 0x4 (APB, pready always high).
module limit_order_book_matcher #(
    parameter int NUM_BOOKS  = 4,
    parameter int BOOK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_side,
    input  logic [63:0] i_in_limit_price,
    input  logic [63:0] i_in_order_qty,
    input  logic [1:0]  i_in_book_index,
    input  logic [63:0] i_in_gas_limit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_status,
    output logic [63:0] o_out_filled_qty,
    output logic [63:0] o_out_avg_price,
    output logic [6:0]  o_out_num_fills,
    output logic [22:0] o_out_gas_charge,
    output logic        o_out_rest_dropped
);

`include "assert_macros.svh"

    logic [15:0]   r_gas_base;
    logic [15:0]   r_gas_per_fill;
    logic          cfg_wr;
    lob_pkg::t_cmd cmd;
    lob_pkg::t_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_base     <= lob_pkg::GAS_BASE_RST;
            r_gas_per_fill <= lob_pkg::GAS_PER_FILL_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                lob_pkg::CFG_GAS_BASE:     r_gas_base     <= pwdata[15:0];
                lob_pkg::CFG_GAS_PER_FILL: r_gas_per_fill <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            lob_pkg::CFG_GAS_BASE:     prdata = {16'd0, r_gas_base};
            lob_pkg::CFG_GAS_PER_FILL: prdata = {16'd0, r_gas_per_fill};
            default:                   prdata = '0;
        endcase
    end

    lob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    lob_dp #(
        .NUM_BOOKS  (NUM_BOOKS),
        .BOOK_DEPTH (BOOK_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_gas_base         (r_gas_base),
        .i_gas_per_fill     (r_gas_per_fill),
        .i_in_side          (i_in_side),
        .i_in_limit_price   (i_in_limit_price),
        .i_in_order_qty     (i_in_order_qty),
        .i_in_book_index    (i_in_book_index),
        .i_in_gas_limit     (i_in_gas_limit),
        .o_out_status       (o_out_status),
        .o_out_filled_qty   (o_out_filled_qty),
        .o_out_avg_price    (o_out_avg_price),
        .o_out_num_fills    (o_out_num_fills),
        .o_out_gas_charge   (o_out_gas_charge),
        .o_out_rest_dropped (o_out_rest_dropped)
    );

    // a taken request keeps the input side busy on the next cycle
    `LOB_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // a new result only appears out of the busy sequence
    `LOB_ASSERT_IMP(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall))
    // nothing filled means no average price
    `LOB_ASSERT(a_avg_zero, !o_out_valid || o_out_filled_qty != 64'd0 || o_out_avg_price == 64'd0)

endmodule

// ===== verif/tb_limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// Self-checking bench for limit_order_book_matcher: directed orders, then random flow.
// Needs lob_pkg and the matcher RTL; a behavioral book model predicts every result.
module tb_limit_order_book_matcher;

    typedef struct {
        bit          side;
        logic [63:0] price;
        logic [63:0] qty;
        logic [1:0]  book;
        logic [63:0] gas;
    } order_t;

    typedef struct {
        logic        status;
        logic [63:0] filled;
        logic [63:0] avg;
        logic [6:0]  fills;
        logic [22:0] gas_chg;
        logic        dropped;
    } report_t;

    typedef struct {
        order_t  o;
        bit      known;
        report_t r;
    } row_t;

    localparam int DEPTH = 64;
    localparam logic [63:0] MAX64 = '1;
    localparam bit BID = 1'b0;
    localparam bit ASK = 1'b1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_in_side = 1'b0;
    logic [63:0] i_in_limit_price = '0, i_in_order_qty = '0, i_in_gas_limit = '0;
    logic [1:0]  i_in_book_index = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_out_status, o_out_rest_dropped;
    logic [63:0] o_out_filled_qty, o_out_avg_price;
    logic [6:0]  o_out_num_fills;
    logic [22:0] o_out_gas_charge;

    limit_order_book_matcher uut (.*);

    always #5 i_clk = ~i_clk;

    // model state: [side][book][slot], side 0 bids (high first), 1 asks (low first)
    logic [63:0] lvl_price [2][4][DEPTH];
    logic [63:0] lvl_qty   [2][4][DEPTH];
    int          lvl_count [2][4];
    logic [15:0] base_gas, fill_gas;

    report_t fill_reports[$];
    int      errors = 0;
    bit      calm = 1'b0;

    function automatic report_t match_order(order_t o);
        report_t     r;
        bit          own, opp;
        logic [63:0] rem, tp, tq, fq;
        logic [127:0] notional;
        logic [63:0] gas_total;
        int          b, n, pos, k, fills;
        r = '{default: '0};
        if (o.gas < {48'd0, base_gas}) begin
            r.status = 1'b1;
            return r;
        end
        own = o.side;
        opp = ~o.side;
        b = int'(o.book);
        rem = o.qty;
        notional = '0;
        fills = 0;
        while (lvl_count[opp][b] > 0 && rem != 0) begin
            tp = lvl_price[opp][b][0];
            tq = lvl_qty[opp][b][0];
            if (own == BID ? (tp > o.price) : (o.price > tp)) break;
            fq = (rem < tq) ? rem : tq;
            notional += {64'd0, fq} * {64'd0, tp};
            r.filled += fq;
            rem -= fq;
            if (fq < tq) begin
                lvl_qty[opp][b][0] = tq - fq;
            end else begin
                n = lvl_count[opp][b];
                for (k = 1; k < n; k++) begin
                    lvl_price[opp][b][k-1] = lvl_price[opp][b][k];
                    lvl_qty[opp][b][k-1] = lvl_qty[opp][b][k];
                end
                lvl_count[opp][b] = n - 1;
            end
            fills++;
        end
        if (rem != 0) begin
            n = lvl_count[own][b];
            if (n >= DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                pos = 0;
                // equal prices queue behind
                while (pos < n && !(own == BID ? (o.price > lvl_price[own][b][pos])
                                               : (o.price < lvl_price[own][b][pos])))
                    pos++;
                for (k = n; k > pos; k--) begin
                    lvl_price[own][b][k] = lvl_price[own][b][k-1];
                    lvl_qty[own][b][k] = lvl_qty[own][b][k-1];
                end
                lvl_price[own][b][pos] = o.price;
                lvl_qty[own][b][pos] = rem;
                lvl_count[own][b] = n + 1;
            end
        end
        gas_total = base_gas + 64'(fills) * fill_gas;
        if (r.filled != 0) r.avg = 64'(notional / {64'd0, r.filled});
        r.status = gas_total > o.gas;
        r.fills = 7'(fills);
        r.gas_chg = gas_total[22:0];
        return r;
    endfunction

    task automatic cfg_write(input logic [0:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = {16'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == lob_pkg::CFG_GAS_BASE) base_gas = value;
        else fill_gas = value;
    endtask

    // send one request; the prediction is taken at the accepting edge
    task automatic send(input order_t o, input bit known, input report_t typed);
        report_t r;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_side = o.side; i_in_limit_price = o.price; i_in_order_qty = o.qty;
        i_in_book_index = o.book; i_in_gas_limit = o.gas;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = match_order(o);
        fill_reports.push_back(known ? typed : r);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (fill_reports.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // mostly book traffic near one price band, some noise
    function automatic order_t rnd_order(int band);
        order_t o;
        int     pick;
        o.side = 1'($urandom_range(1));
        o.book = 2'($urandom_range(3));
        o.price = 64'(band - 30 + int'($urandom_range(60)));
        o.qty = 64'($urandom_range(1, 120));
        o.gas = 64'd4_000_000 + 64'($urandom_range(1000));
        pick = int'($urandom_range(99));
        if (pick < 6) o.price = rnd64();
        else if (pick < 10) o.qty = rnd64();
        else if (pick < 13) o.qty = 64'd0;
        else if (pick < 18) o.gas = rnd64();
        else if (pick < 23)
            o.gas = 64'(base_gas) + 64'($urandom_range(3)) * 64'(fill_gas);
        else if (pick < 27 && base_gas > 0)
            o.gas = 64'(base_gas) - 64'($urandom_range(1, 32'(base_gas)));
        else if (pick < 30) o.qty = 64'($urandom_range(300, 3000));
        return o;
    endfunction

    task automatic random_run(int count, int band);
        report_t none;
        none = '{default: '0};
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 3 + 30);
            send(rnd_order(band), 1'b0, none);
        end
        calm = 1'b0;
    endtask

    always @(negedge i_clk)
        i_out_stall = calm ? 1'b0 : ($urandom_range(99) < 36);

    always @(posedge i_clk) begin
        report_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (fill_reports.size() == 0) begin
                $display("%0t: result with none pending, status %0d filled %0d",
                         $time, o_out_status, o_out_filled_qty);
                errors++;
            end else begin
                e = fill_reports.pop_front();
                if (o_out_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_out_status);
                    errors++;
                end
                if (o_out_filled_qty !== e.filled) begin
                    $display("%0t: filled exp %0d got %0d", $time, e.filled, o_out_filled_qty);
                    errors++;
                end
                if (o_out_avg_price !== e.avg) begin
                    $display("%0t: avg exp %0d got %0d", $time, e.avg, o_out_avg_price);
                    errors++;
                end
                if (o_out_num_fills !== e.fills) begin
                    $display("%0t: fills exp %0d got %0d", $time, e.fills, o_out_num_fills);
                    errors++;
                end
                if (o_out_gas_charge !== e.gas_chg) begin
                    $display("%0t: gas exp %0d got %0d", $time, e.gas_chg, o_out_gas_charge);
                    errors++;
                end
                if (o_out_rest_dropped !== e.dropped) begin
                    $display("%0t: dropped exp %0d got %0d", $time, e.dropped,
                             o_out_rest_dropped);
                    errors++;
                end
            end
        end
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        row_t    plan[$];
        report_t none;
        order_t  o;
        none = '{default: '0};
        base_gas = lob_pkg::GAS_BASE_RST;
        fill_gas = lob_pkg::GAS_PER_FILL_RST;
        foreach (lvl_count[s, b]) lvl_count[s][b] = 0;

        plan = '{
            '{'{BID, 64'd100, 64'd10, 2'd0, MAX64}, 1, '{0, 0, 0, 0, 1500, 0}},
            '{'{ASK, 64'd90, 64'd4, 2'd0, MAX64}, 1, '{0, 4, 100, 1, 1850, 0}},
            '{'{ASK, 64'd100, 64'd0, 2'd0, MAX64}, 1, '{0, 0, 0, 0, 1500, 0}},
            '{'{BID, 64'd5, 64'd1, 2'd1, 64'd0}, 1, '{1, 0, 0, 0, 0, 0}},
            '{'{BID, 64'd5, 64'd1, 2'd1, 64'd1499}, 1, '{1, 0, 0, 0, 0, 0}},
            '{'{BID, 64'd5, 64'd1, 2'd1, 64'd1500}, 1, '{0, 0, 0, 0, 1500, 0}},
            '{'{ASK, MAX64, MAX64, 2'd2, MAX64}, 1, '{0, 0, 0, 0, 1500, 0}},
            '{'{BID, MAX64, MAX64, 2'd2, 64'd1500}, 1, '{1, MAX64, MAX64, 1, 1850, 0}},
            '{'{BID, 64'd0, 64'd7, 2'd3, MAX64}, 0, none},
            '{'{ASK, 64'd0, 64'd3, 2'd3, MAX64}, 0, none},
            '{'{BID, 64'd200, 64'd5, 2'd3, MAX64}, 0, none},
            '{'{BID, 64'd200, 64'd6, 2'd3, MAX64}, 0, none},
            '{'{BID, 64'd150, 64'd9, 2'd3, MAX64}, 0, none},
            '{'{ASK, 64'd0, 64'd20, 2'd3, MAX64}, 0, none},
            '{'{ASK, 64'd300, 64'd8, 2'd1, MAX64}, 0, none},
            '{'{ASK, 64'd250, 64'd8, 2'd1, MAX64}, 0, none},
            '{'{BID, 64'd400, 64'd12, 2'd1, 64'd1850}, 0, none},
            '{'{BID, 64'h8000_0000_0000_0001, 64'd3, 2'd0, 64'hAAAA_5555_AAAA_5555}, 0, none}
        };

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) send(plan[i].o, plan[i].known, plan[i].r);
        drain();

        random_run(120, 1000);

        // fill and overflow one bid side and one ask side, then sweep the bids with one ask
        drain();
        cfg_write(lob_pkg::CFG_GAS_BASE, 16'd0);
        cfg_write(lob_pkg::CFG_GAS_PER_FILL, 16'd65535);
        for (int i = 0; i < DEPTH + 4; i++) begin
            o = '{BID, 64'($urandom_range(1, 500)), 64'($urandom_range(1, 50)), 2'd2,
                  MAX64};
            send(o, 1'b0, none);
        end
        for (int i = 0; i < DEPTH + 3; i++) begin
            o = '{ASK, 64'($urandom_range(100000, 200000)), 64'($urandom_range(1, 50)),
                  2'd2, MAX64};
            send(o, 1'b0, none);
        end
        send('{ASK, 64'd0, MAX64, 2'd2, 64'd1000}, 1'b0, none);
        random_run(100, 700);

        // hold off until the block has answered everything
        drain();
        cfg_write(lob_pkg::CFG_GAS_BASE, 16'd65535);
        cfg_write(lob_pkg::CFG_GAS_PER_FILL, 16'd0);
        random_run(80, 5000);

        drain();
        cfg_write(lob_pkg::CFG_GAS_BASE, 16'd900);
        cfg_write(lob_pkg::CFG_GAS_PER_FILL, 16'd120);
        random_run(100, 3000);

        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/lob_pkg.sv
src/lob_ctrl.sv
src/lob_dp.sv
src/limit_order_book_matcher.sv
verif/tb_limit_order_book_matcher.sv
